>>> rtl/core/cfd_pkg.sv
// Package with the constants, types and command lookup of the command frame decoder.
package cfd_pkg;

    localparam int MAX_PAYLOAD = 8;
    localparam int PAY_IW      = $clog2(MAX_PAYLOAD);
    localparam int SIM_COUNT   = 7;

    localparam logic [7:0]  HDR_FIRST      = 8'hAA;
    localparam logic [7:0]  HDR_SECOND     = 8'h14;
    localparam logic [7:0]  RESET_BYTE     = 8'hFF;
    localparam logic [2:0]  RESET_RUN      = 3'd4;
    localparam logic [15:0] DEFAULT_PERIOD = 16'd10;

    localparam logic [7:0] CMD_ECHO    = 8'h00;
    localparam logic [7:0] CMD_LED_ON  = 8'h01;
    localparam logic [7:0] CMD_LED_OFF = 8'h02;
    localparam logic [7:0] CMD_CLEAR   = 8'h03;
    localparam logic [7:0] CMD_MODE    = 8'h04;
    localparam logic [7:0] CMD_OPEN    = 8'h10;
    localparam logic [7:0] CMD_CLOSE   = 8'h11;
    localparam logic [7:0] CMD_PARAMS  = 8'h20;
    localparam logic [7:0] CMD_SHOW    = 8'h21;
    localparam logic [7:0] CMD_BANNER  = 8'h3A;
    localparam logic [7:0] CMD_DUMP    = 8'h44;
    localparam logic [7:0] CMD_SIM     = 8'h50;

    localparam logic [3:0] EV_ECHO    = 4'd0;
    localparam logic [3:0] EV_LED_ON  = 4'd1;
    localparam logic [3:0] EV_LED_OFF = 4'd2;
    localparam logic [3:0] EV_CLEAR   = 4'd3;
    localparam logic [3:0] EV_MODE    = 4'd4;
    localparam logic [3:0] EV_OPEN    = 4'd5;
    localparam logic [3:0] EV_CLOSE   = 4'd6;
    localparam logic [3:0] EV_PARAMS  = 4'd7;
    localparam logic [3:0] EV_SHOW    = 4'd8;
    localparam logic [3:0] EV_BANNER  = 4'd9;
    localparam logic [3:0] EV_DUMP    = 4'd10;
    localparam logic [3:0] EV_SIM     = 4'd11;
    localparam logic [3:0] EV_RESET   = 4'd12;

    localparam logic [3:0] NEED_MODE   = 4'd1;
    localparam logic [3:0] NEED_PARAMS = 4'd3;
    localparam logic [3:0] NEED_SIM    = 4'd8;

    localparam int OUT_W = 96;

    typedef struct packed {
        logic       known;
        logic [3:0] ev;
        logic [3:0] need;
    } cmd_info_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] code;
    } event_t;

    typedef struct packed {
        logic [SIM_COUNT-1:0][7:0] sim;
        logic [7:0]                limit;
        logic [15:0]               period;
        logic [7:0]                mode;
    } store_t;

    function automatic cmd_info_t lookup_command(input logic [7:0] c);
        cmd_info_t r;
        r.known = 1'b1;
        r.ev    = EV_ECHO;
        r.need  = 4'd0;
        case (c)
            CMD_ECHO:    r.ev = EV_ECHO;
            CMD_LED_ON:  r.ev = EV_LED_ON;
            CMD_LED_OFF: r.ev = EV_LED_OFF;
            CMD_CLEAR:   r.ev = EV_CLEAR;
            CMD_MODE:
            begin
                r.ev   = EV_MODE;
                r.need = NEED_MODE;
            end
            CMD_OPEN:    r.ev = EV_OPEN;
            CMD_CLOSE:   r.ev = EV_CLOSE;
            CMD_PARAMS:
            begin
                r.ev   = EV_PARAMS;
                r.need = NEED_PARAMS;
            end
            CMD_SHOW:    r.ev = EV_SHOW;
            CMD_BANNER:  r.ev = EV_BANNER;
            CMD_DUMP:    r.ev = EV_DUMP;
            CMD_SIM:
            begin
                r.ev   = EV_SIM;
                r.need = NEED_SIM;
            end
            default:     r.known = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] frame_total(input logic [7:0] len, input logic [3:0] need);
        logic [7:0] min_len;
        min_len = {4'd0, need} + 8'd1;
        return (len > min_len) ? len : min_len;
    endfunction

endpackage

>>> rtl/core/command_frame_decoder.sv
// Top level of the command frame decoder: byte stream in, event stream out.
//
//   Channel   Dir  Width  Contents
//   s_axis    in   8      one received byte
//   m_axis    out  96     event with the stored registers after it took effect
//
// Each byte is decoded in the cycle it is accepted, and its event, if any, is
// loaded into the output register at that edge, so one byte per cycle is taken while the output side does not stall.
// A new byte is accepted while the output register is empty or being drained.
// Reset restores the hunting state and a period of ten and clears the other stored
// registers; the payload buffer and the output data register are not reset.
// A stall on the output side holds the pending event and stops the input side.
module command_frame_decoder
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // rx_byte[7:0]
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [cfd_pkg::OUT_W-1:0] m_axis_tdata  // event_res[3:0], mode_now[11:4],
                                                    // period_ms[27:12], time_limit[35:28],
                                                    // sim_status[43:36], sim_press_ox[51:44],
                                                    // sim_press_comb[59:52], sim_temp_pre[67:60],
                                                    // sim_temp_comb[75:68], sim_thrust[83:76],
                                                    // sim_new_data[91:84], zero[95:92]
);
    import cfd_pkg::*;

    event_t            ev;
    store_t            store_next;
    logic              accept;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cfd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (accept),
        .rx_byte    (s_axis_tdata),
        .ev         (ev),
        .store_next (store_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && ev.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && ev.valid)
        begin
            out_data_reg <= {4'd0, store_next.sim, store_next.limit, store_next.period,
                             store_next.mode, ev.code};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/core/cfd_parser.sv
// Frame parser of the command frame decoder: header hunt, frame state and stored registers.
module cfd_parser
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    input  logic [7:0]     rx_byte,
    output cfd_pkg::event_t ev,
    output cfd_pkg::store_t store_next
);
    import cfd_pkg::*;

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_CMD   = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic [7:0] frame_len_reg, frame_len_next;
    logic [7:0] bytes_seen_reg, bytes_seen_next;
    logic [7:0] command_reg, command_next;
    logic [2:0] ff_run_reg, ff_run_next;
    store_t     store_reg;
    logic [MAX_PAYLOAD-1:0][7:0] payload_reg, payload_next;

    cmd_info_t  info_byte, info_cmd, info_fin;
    logic       hunt, done;
    logic [7:0] fin_cmd, idx;
    logic [15:0] period_new;

    assign info_byte = lookup_command(rx_byte);
    assign info_cmd  = lookup_command(command_reg);
    assign info_fin  = lookup_command(fin_cmd);

    always_comb
    begin
        phase_next      = phase_reg;
        frame_len_next  = frame_len_reg;
        bytes_seen_next = bytes_seen_reg;
        command_next    = command_reg;
        ff_run_next     = ff_run_reg;
        payload_next    = payload_reg;
        store_next      = store_reg;
        ev.valid        = 1'b0;
        ev.code         = EV_ECHO;
        hunt            = 1'b0;
        done            = 1'b0;
        fin_cmd         = command_reg;
        idx             = bytes_seen_reg - 8'd1;
        period_new      = {payload_next[1], payload_next[0]};
        if (byte_valid)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    frame_len_next = rx_byte;
                    phase_next     = PH_CMD;
                    ff_run_next    = 3'd0;
                end
                PH_CMD:
                begin
                    if (info_byte.known)
                    begin
                        command_next    = rx_byte;
                        bytes_seen_next = 8'd1;
                        ff_run_next     = 3'd0;
                        if (8'd1 >= frame_total(frame_len_reg, info_byte.need))
                        begin
                            done    = 1'b1;
                            fin_cmd = rx_byte;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                    else
                    begin
                        hunt = 1'b1;
                    end
                end
                PH_BODY:
                begin
                    if (idx < {4'd0, info_cmd.need} && idx < 8'(MAX_PAYLOAD))
                    begin
                        payload_next[idx[PAY_IW-1:0]] = rx_byte;
                    end
                    bytes_seen_next = bytes_seen_reg + 8'd1;
                    ff_run_next     = 3'd0;
                    if (bytes_seen_next >= frame_total(frame_len_reg, info_cmd.need))
                    begin
                        done = 1'b1;
                    end
                end
                default:
                begin
                    hunt = 1'b1;
                end
            endcase

            period_new = {payload_next[1], payload_next[0]};

            if (done)
            begin
                case (fin_cmd)
                    CMD_MODE:
                    begin
                        store_next.mode = payload_next[0];
                    end
                    CMD_PARAMS:
                    begin
                        store_next.period = (period_new == 16'd0) ? DEFAULT_PERIOD : period_new;
                        store_next.limit  = payload_next[2];
                    end
                    CMD_SIM:
                    begin
                        store_next.mode = payload_next[0];
                        for (int k = 0; k < SIM_COUNT; k++)
                        begin
                            store_next.sim[k] = payload_next[k + 1];
                        end
                    end
                    default:
                    begin
                        store_next = store_reg;
                    end
                endcase
                phase_next      = PH_HUNT1;
                bytes_seen_next = 8'd0;
                ev.valid        = 1'b1;
                ev.code         = info_fin.ev;
            end

            if (hunt)
            begin
                if (rx_byte == RESET_BYTE)
                begin
                    if (ff_run_reg < RESET_RUN)
                    begin
                        ff_run_next = ff_run_reg + 3'd1;
                    end
                end
                else
                begin
                    ff_run_next = 3'd0;
                end
                if (phase_reg == PH_HUNT2 && rx_byte == HDR_SECOND)
                begin
                    phase_next = PH_LEN;
                end
                else if (rx_byte == HDR_FIRST)
                begin
                    phase_next = PH_HUNT2;
                end
                else
                begin
                    phase_next = PH_HUNT1;
                end
                if (ff_run_next >= RESET_RUN)
                begin
                    phase_next        = PH_HUNT1;
                    frame_len_next    = 8'd0;
                    bytes_seen_next   = 8'd0;
                    command_next      = 8'd0;
                    ff_run_next       = 3'd0;
                    store_next.mode   = 8'd0;
                    store_next.period = DEFAULT_PERIOD;
                    store_next.limit  = 8'd0;
                    store_next.sim    = '0;
                    ev.valid          = 1'b1;
                    ev.code           = EV_RESET;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT1;
            frame_len_reg    <= 8'd0;
            bytes_seen_reg   <= 8'd0;
            command_reg      <= 8'd0;
            ff_run_reg       <= 3'd0;
            store_reg.mode   <= 8'd0;
            store_reg.period <= DEFAULT_PERIOD;
            store_reg.limit  <= 8'd0;
            store_reg.sim    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            frame_len_reg  <= frame_len_next;
            bytes_seen_reg <= bytes_seen_next;
            command_reg    <= command_next;
            ff_run_reg     <= ff_run_next;
            store_reg      <= store_next;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
    end

endmodule

>>> sim/tb_command_frame_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for command_frame_decoder: byte streams in, predicted events checked out.
module tb_command_frame_decoder;
    import cfd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1900;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 200;

    typedef enum logic [2:0]
    {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_LEN,
        TAKE_CMD,
        TAKE_BODY
    } rx_phase_t;

    typedef struct packed {
        logic [3:0]                code;
        logic [7:0]                mode;
        logic [15:0]               period;
        logic [7:0]                limit;
        logic [SIM_COUNT-1:0][7:0] sim;
    } decoder_event_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;

    rx_phase_t                 dec_phase;
    logic [7:0]                frame_len;
    logic [7:0]                bytes_seen;
    logic [7:0]                cur_cmd;
    logic [7:0]                payload_buf [MAX_PAYLOAD];
    logic [2:0]                ff_count;
    logic [7:0]                mode_reg;
    logic [15:0]               period_reg;
    logic [7:0]                limit_reg;
    logic [SIM_COUNT-1:0][7:0] sim_reg;

    decoder_event_t pending_events [$];
    int             error_count = 0;
    int             byte_count = 0;
    int             burst_left = 0;
    int             drain_left = 0;
    int             stall_level = 0;
    int             cycle_count = 0;
    bit             sender_idles = 1'b1;
    bit             stalls_on = 1'b1;

    command_frame_decoder uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic bit classify_command(input logic [7:0] c, output logic [3:0] code,
                                            output logic [3:0] need);
        need = 4'd0;
        code = EV_ECHO;
        case (c)
            CMD_ECHO:    code = EV_ECHO;
            CMD_LED_ON:  code = EV_LED_ON;
            CMD_LED_OFF: code = EV_LED_OFF;
            CMD_CLEAR:   code = EV_CLEAR;
            CMD_MODE:
            begin
                code = EV_MODE;
                need = NEED_MODE;
            end
            CMD_OPEN:    code = EV_OPEN;
            CMD_CLOSE:   code = EV_CLOSE;
            CMD_PARAMS:
            begin
                code = EV_PARAMS;
                need = NEED_PARAMS;
            end
            CMD_SHOW:    code = EV_SHOW;
            CMD_BANNER:  code = EV_BANNER;
            CMD_DUMP:    code = EV_DUMP;
            CMD_SIM:
            begin
                code = EV_SIM;
                need = NEED_SIM;
            end
            default:     return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic void clear_decoder_state();
        dec_phase  = HUNT_FIRST;
        frame_len  = 8'd0;
        bytes_seen = 8'd0;
        cur_cmd    = 8'd0;
        foreach (payload_buf[i])
            payload_buf[i] = 8'd0;
        ff_count   = 3'd0;
        mode_reg   = 8'd0;
        period_reg = DEFAULT_PERIOD;
        limit_reg  = 8'd0;
        sim_reg    = '0;
    endfunction

    function automatic decoder_event_t snapshot(input logic [3:0] code);
        decoder_event_t ev;
        ev.code   = code;
        ev.mode   = mode_reg;
        ev.period = period_reg;
        ev.limit  = limit_reg;
        ev.sim    = sim_reg;
        return ev;
    endfunction

    function automatic logic [7:0] frame_span(input logic [3:0] need);
        logic [7:0] min_len;
        min_len = {4'd0, need} + 8'd1;
        return (frame_len > min_len) ? frame_len : min_len;
    endfunction

    function automatic decoder_event_t close_frame();
        logic [3:0] code;
        logic [3:0] need;
        void'(classify_command(cur_cmd, code, need));
        case (cur_cmd)
            CMD_MODE:
                mode_reg = payload_buf[0];
            CMD_PARAMS:
            begin
                period_reg = {payload_buf[1], payload_buf[0]};
                if (period_reg == 16'd0)
                    period_reg = DEFAULT_PERIOD;
                limit_reg = payload_buf[2];
            end
            CMD_SIM:
            begin
                mode_reg = payload_buf[0];
                for (int k = 0; k < SIM_COUNT; k++)
                    sim_reg[k] = payload_buf[k + 1];
            end
            default:
                ;
        endcase
        dec_phase  = HUNT_FIRST;
        bytes_seen = 8'd0;
        return snapshot(code);
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output decoder_event_t ev_out);
        logic [3:0] code;
        logic [3:0] need;
        logic [7:0] idx;
        bit         from_second;
        ev_out = '0;
        if (dec_phase == TAKE_LEN)
        begin
            frame_len = b;
            dec_phase = TAKE_CMD;
            ff_count  = 3'd0;
            return 1'b0;
        end
        if (dec_phase == TAKE_CMD && classify_command(b, code, need))
        begin
            cur_cmd    = b;
            bytes_seen = 8'd1;
            ff_count   = 3'd0;
            if (bytes_seen >= frame_span(need))
            begin
                ev_out = close_frame();
                return 1'b1;
            end
            dec_phase = TAKE_BODY;
            return 1'b0;
        end
        if (dec_phase == TAKE_BODY)
        begin
            void'(classify_command(cur_cmd, code, need));
            idx = bytes_seen - 8'd1;
            if (idx < {4'd0, need} && idx < 8'(MAX_PAYLOAD))
                payload_buf[idx[PAY_IW-1:0]] = b;
            bytes_seen = bytes_seen + 8'd1;
            ff_count   = 3'd0;
            if (bytes_seen >= frame_span(need))
            begin
                ev_out = close_frame();
                return 1'b1;
            end
            return 1'b0;
        end

        // An unknown command byte falls through and is treated as a hunting byte.
        from_second = (dec_phase == HUNT_SECOND);
        if (b == RESET_BYTE)
        begin
            if (ff_count < RESET_RUN)
                ff_count = ff_count + 3'd1;
        end
        else
            ff_count = 3'd0;
        if (from_second && b == HDR_SECOND)
            dec_phase = TAKE_LEN;
        else if (b == HDR_FIRST)
            dec_phase = HUNT_SECOND;
        else
            dec_phase = HUNT_FIRST;
        if (ff_count >= RESET_RUN)
        begin
            clear_decoder_state();
            ev_out = snapshot(EV_RESET);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
    endtask

    task automatic send_byte(input logic [7:0] b);
        decoder_event_t ev;
        int             gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_idles ? $urandom_range(0, 6) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (decode_byte(b, ev))
            pending_events.push_back(ev);
        byte_count++;
    endtask

    task automatic send_header();
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return RESET_BYTE;
            1:       return HDR_FIRST;
            2:       return HDR_SECOND;
            3:       return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_good_frame();
        logic [7:0] cmd;
        logic [7:0] len;
        logic [3:0] code;
        logic [3:0] need;
        int         roll;
        int         span;
        int         period_kind;
        do
            cmd = 8'($urandom_range(0, 255));
        while (!classify_command(cmd, code, need));
        roll = $urandom_range(0, 99);
        if (roll < 45)
            len = 8'($urandom_range(0, int'(need) + 1));
        else if (roll < 99)
            len = 8'($urandom_range(int'(need) + 1, int'(need) + 6));
        else
            len = 8'($urandom_range(16, 255));
        span = (int'(len) > int'(need) + 1) ? int'(len) : int'(need) + 1;
        period_kind = $urandom_range(0, 5);
        send_header();
        send_byte(len);
        send_byte(cmd);
        for (int k = 0; k < span - 1; k++)
        begin
            if (cmd == CMD_PARAMS && k < 2 && period_kind == 0)
                send_byte(8'h00);
            else if (cmd == CMD_PARAMS && k < 2 && period_kind == 1)
                send_byte(8'hFF);
            else
                send_byte(pick_byte());
        end
    endtask

    task automatic send_broken_sequence();
        logic [7:0] cmd;
        logic [3:0] code;
        logic [3:0] need;
        case ($urandom_range(0, 2))
            0:
            begin
                send_byte(HDR_FIRST);
                send_byte(pick_byte());
            end
            1:
            begin
                do
                    cmd = 8'($urandom_range(0, 255));
                while (classify_command(cmd, code, need));
                send_header();
                send_byte(pick_byte());
                send_byte(cmd);
            end
            default:
            begin
                do
                    cmd = 8'($urandom_range(0, 255));
                while (!classify_command(cmd, code, need));
                send_header();
                send_byte(pick_byte());
                send_byte(cmd);
                repeat ($urandom_range(0, int'(need))) send_byte(pick_byte());
            end
        endcase
    endtask

    task automatic test_soft_reset();
        repeat (4) send_byte(RESET_BYTE);
    endtask

    task automatic test_repeated_header_zero_period();
        logic [7:0] seq [8] = '{HDR_FIRST, HDR_FIRST, HDR_SECOND, 8'h00,
                                CMD_PARAMS, 8'h00, 8'h00, 8'h07};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_mode_extra_length();
        logic [7:0] seq [6] = '{HDR_FIRST, HDR_SECOND, 8'h03, CMD_MODE, 8'h80, 8'h33};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_unknown_command();
        logic [7:0] seq [7] = '{HDR_FIRST, HDR_SECOND, 8'h01, HDR_FIRST, HDR_SECOND,
                                8'h00, CMD_ECHO};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_random_traffic();
        int start;
        int roll;
        start = byte_count;
        while (byte_count - start < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 39) == 0)
                sender_idles = !sender_idles;
            if ($urandom_range(0, 39) == 0)
                stalls_on = !stalls_on;
            roll = $urandom_range(0, 99);
            if (roll < 75)
                send_good_frame();
            else if (roll < 83)
                repeat ($urandom_range(1, 6)) send_byte(pick_byte());
            else if (roll < 88)
                repeat ($urandom_range(4, 5)) send_byte(RESET_BYTE);
            else
                send_broken_sequence();
        end
    endtask

    always @(negedge clk)
    begin
        if (drain_left == 0)
        begin
            drain_left  = $urandom_range(8, 64);
            stall_level = stalls_on ? $urandom_range(0, 3) : 0;
        end
        drain_left--;
        m_axis_tready <= ($urandom_range(0, 3) >= stall_level);
    end

    always @(posedge clk)
    begin : event_check
        decoder_event_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_events.size() == 0)
                report_error($sformatf("event %0d arrived with no transaction pending",
                                       m_axis_tdata[3:0]));
            else
            begin
                want = pending_events.pop_front();
                check_field("event_res", 16'(m_axis_tdata[3:0]), 16'(want.code));
                check_field("mode_now", 16'(m_axis_tdata[11:4]), 16'(want.mode));
                check_field("period_ms", m_axis_tdata[27:12], want.period);
                check_field("time_limit", 16'(m_axis_tdata[35:28]), 16'(want.limit));
                for (int k = 0; k < SIM_COUNT; k++)
                    check_field($sformatf("sim byte %0d", k),
                                16'(m_axis_tdata[36 + 8 * k +: 8]), 16'(want.sim[k]));
                check_field("padding", 16'(m_axis_tdata[95:92]), 16'd0);
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_command_frame_decoder failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        m_axis_tready = 1'b0;
        clear_decoder_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_soft_reset();
        test_repeated_header_zero_period();
        test_mode_extra_length();
        test_unknown_command();
        test_random_traffic();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_command_frame_decoder passed");
        else
            $display("tb_command_frame_decoder failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/cfd_pkg.sv
rtl/core/cfd_parser.sv
rtl/core/command_frame_decoder.sv
sim/tb_command_frame_decoder.sv
